/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the URI encoder modules.
// Depends on nothing; each asserting file includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hw/rtl/uri_enc_pkg.sv */
// Types, constants and character-class functions for the URI percent encoder.
// Depends on nothing; imported by every module of the block.
package uri_enc_pkg;

	typedef enum logic [1:0] {
		JOB_CHAR,
		JOB_ERROR,
		JOB_ESCAPE
	} job_kind_t;

	// One unit of work handed from the front end to the back end.
	typedef struct packed {
		job_kind_t        kind;
		logic [6:0]       ch;
		logic [3:0][7:0]  octets;
		logic [1:0]       oct_last;
		logic             str_end;
	} job_t;

	localparam logic [6:0] CHAR_PERCENT = 7'h25;
	localparam logic [6:0] CHAR_NUL     = 7'h00;

	function automatic logic is_unreserved(input logic [15:0] u);
		return u inside {[16'h0041:16'h005A], [16'h0061:16'h007A], [16'h0030:16'h0039],
			16'h002D, 16'h005F, 16'h002E, 16'h0021, 16'h007E, 16'h002A,
			16'h0027, 16'h0028, 16'h0029};
	endfunction

	function automatic logic is_reserved_or_hash(input logic [15:0] u);
		return u inside {16'h003B, 16'h002F, 16'h003F, 16'h003A, 16'h0040, 16'h0026,
			16'h003D, 16'h002B, 16'h0024, 16'h002C, 16'h0023};
	endfunction

	// Upper-case ASCII hex digit for one nibble.
	function automatic logic [6:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (7'h30 + {3'b000, n}) : (7'h37 + {3'b000, n});
	endfunction

endpackage

/* hw/rtl/uri_percent_encoder_top.sv */
// URI percent encoder: top level, joining front end, job queue and back end.
// Depends on uri_enc_pkg, uri_enc_front, uri_enc_jobq and uri_enc_back.
//
// Usage. The input side is a queue: drive code_unit and string_end with push
// high; the unit is transferred on a rising edge where push is high and full is
// low. Set string_end on the last unit of each string. The result side is also
// a queue: while empty is low, out_char, run_last, string_done and malformed
// hold the oldest character, and a transfer happens on an edge where pop is
// high. run_last marks the final character of one input unit's output, and
// string_done marks the final character of a string's output or an error.
// A lone surrogate gives one error result (malformed high, out_char zero), and
// the units after it up to the end of the string give nothing.
// Timing. The front end classifies a unit in the cycle it is transferred and
// stores a job in a two-entry queue. The back end emits one character per
// cycle into the result register while it is empty or being popped; a unit
// passes the job queue and then the result register. A plain character gives
// one output character, an escaped octet three, and a scalar up to twelve; the
// back end's output sets the rate, and the queue takes units while it works. When
// the receiver stops popping, the result register holds, the job queue fills, and
// full rises; nothing is lost. Reset clears the control state and sets mode to 1.
module uri_percent_encoder_top import uri_enc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [15:0] code_unit,
	input  logic        string_end,
	output logic        empty,
	input  logic        pop,
	output logic [6:0]  out_char,
	output logic        run_last,
	output logic        string_done,
	output logic        malformed
);

	logic component_mode_q;
	logic accept;
	logic job_push;
	logic job_pop;
	logic job_valid;
	job_t front_job;
	job_t head_job;

	// The user must write the mode register only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			component_mode_q <= 1'b1;
		end else if (cfg_we) begin
			component_mode_q <= cfg_wdata;
		end
	end

	assign accept = push && !full;

	uri_enc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.component_mode (component_mode_q),
		.accept         (accept),
		.code_unit      (code_unit),
		.string_end     (string_end),
		.job_push       (job_push),
		.job            (front_job)
	);

	uri_enc_jobq u_jobq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_data  (front_job),
		.full       (full),
		.pop        (job_pop),
		.head_valid (job_valid),
		.head_data  (head_job)
	);

	uri_enc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job         (head_job),
		.job_pop     (job_pop),
		.pop         (pop),
		.empty       (empty),
		.out_char    (out_char),
		.run_last    (run_last),
		.string_done (string_done),
		.malformed   (malformed)
	);

endmodule

/* hw/rtl/uri_enc_front.sv */
// Front end of the URI encoder: classifies each code unit, pairs surrogates
// and builds the job for the back end. Depends on uri_enc_pkg.
`include "assert_macros.svh"

module uri_enc_front import uri_enc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        component_mode,
	input  logic        accept,
	input  logic [15:0] code_unit,
	input  logic        string_end,
	output logic        job_push,
	output job_t        job
);

	logic [9:0]  held_high_q;
	logic        held_valid_q;
	logic        dropping_q;

	logic        is_high;
	logic        is_low;
	logic        pass;
	logic        err;
	logic        hold;
	logic [20:0] cp;

	assign is_high = (code_unit[15:10] == 6'b110110);
	assign is_low  = (code_unit[15:10] == 6'b110111);
	assign pass    = is_unreserved(code_unit) ||
		(!component_mode && is_reserved_or_hash(code_unit));
	assign cp      = {1'b0, held_high_q, code_unit[9:0]} + 21'h010000;

	always_comb begin
		job          = '0;
		job.kind     = JOB_ESCAPE;
		job.str_end  = string_end;
		err          = 1'b0;
		hold         = 1'b0;
		job_push     = 1'b0;
		if (dropping_q) begin
			job_push = 1'b0;
		end else if (held_valid_q) begin
			if (!is_low) begin
				err = 1'b1;
			end else begin
				job.octets[0] = {5'b11110, cp[20:18]};
				job.octets[1] = {2'b10, cp[17:12]};
				job.octets[2] = {2'b10, cp[11:6]};
				job.octets[3] = {2'b10, cp[5:0]};
				job.oct_last  = 2'd3;
			end
			job_push = accept;
		end else if (pass) begin
			job.kind = JOB_CHAR;
			job.ch   = code_unit[6:0];
			job_push = accept;
		end else if (is_low || (is_high && string_end)) begin
			err      = 1'b1;
			job_push = accept;
		end else if (is_high) begin
			hold = 1'b1;
		end else begin
			if (code_unit[15:7] == 9'd0) begin
				job.octets[0] = code_unit[7:0];
				job.oct_last  = 2'd0;
			end else if (code_unit[15:11] == 5'd0) begin
				job.octets[0] = {3'b110, code_unit[10:6]};
				job.octets[1] = {2'b10, code_unit[5:0]};
				job.oct_last  = 2'd1;
			end else begin
				job.octets[0] = {4'b1110, code_unit[15:12]};
				job.octets[1] = {2'b10, code_unit[11:6]};
				job.octets[2] = {2'b10, code_unit[5:0]};
				job.oct_last  = 2'd2;
			end
			job_push = accept;
		end
		if (err) begin
			job.kind = JOB_ERROR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_high_q  <= '0;
			held_valid_q <= 1'b0;
			dropping_q   <= 1'b0;
		end else if (accept) begin
			if (dropping_q) begin
				if (string_end) begin
					dropping_q <= 1'b0;
				end
			end else if (err) begin
				held_valid_q <= 1'b0;
				held_high_q  <= '0;
				dropping_q   <= !string_end;
			end else if (hold) begin
				held_valid_q <= 1'b1;
				held_high_q  <= code_unit[9:0];
			end else if (held_valid_q) begin
				held_valid_q <= 1'b0;
				held_high_q  <= '0;
			end
		end
	end

	// A pending high surrogate and the discard state never coexist.
	`ASSERT_IMP(a_held_not_dropping, clk, arst_n, held_valid_q, !dropping_q)
	// A pending high surrogate always becomes a job or clears on the next unit.
	`ASSERT_NXT(a_held_resolves, clk, arst_n, accept && held_valid_q, !held_valid_q)
	// A job only leaves the front end with an accepted unit.
	`ASSERT_IMP(a_push_needs_accept, clk, arst_n, job_push, accept)

endmodule

/* hw/rtl/uri_enc_jobq.sv */
// Two-entry job queue between the front end and the back end.
// Depends on uri_enc_pkg for the job type.
`include "assert_macros.svh"

module uri_enc_jobq import uri_enc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_data
);

	job_t ent0_q;
	job_t ent1_q;
	logic v0_q;
	logic v1_q;

	assign full       = v0_q && v1_q;
	assign head_valid = v0_q;
	assign head_data  = ent0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			if (pop && push) begin
				if (v1_q) begin
					ent0_q <= ent1_q;
					ent1_q <= push_data;
				end else begin
					ent0_q <= push_data;
				end
			end else if (pop) begin
				ent0_q <= ent1_q;
				v0_q   <= v1_q;
				v1_q   <= 1'b0;
			end else if (push) begin
				if (!v0_q) begin
					ent0_q <= push_data;
					v0_q   <= 1'b1;
				end else begin
					ent1_q <= push_data;
					v1_q   <= 1'b1;
				end
			end
		end
	end

	`ASSERT_IMP(a_no_push_full, clk, arst_n, push, !full || pop)
	`ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, v0_q)
	`ASSERT_IMP(a_fill_order, clk, arst_n, v1_q, v0_q)

endmodule

/* hw/rtl/uri_enc_back.sv */
// Back end of the URI encoder: expands each job into output characters,
// one per cycle into the result register when free. Depends on uri_enc_pkg.
`include "assert_macros.svh"

module uri_enc_back import uri_enc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	input  job_t       job,
	output logic       job_pop,
	input  logic       pop,
	output logic       empty,
	output logic [6:0] out_char,
	output logic       run_last,
	output logic       string_done,
	output logic       malformed
);

	logic [1:0] oct_idx_q;
	logic [1:0] dig_q;
	logic       out_valid_q;
	logic [6:0] out_char_q;
	logic       run_last_q;
	logic       string_done_q;
	logic       malformed_q;

	logic       adv;
	logic       load;
	logic       last;
	logic [7:0] octet;
	logic [6:0] ch;

	assign adv   = !out_valid_q || pop;
	assign load  = adv && job_valid;
	assign octet = job.octets[oct_idx_q];

	always_comb begin
		ch   = CHAR_NUL;
		last = 1'b1;
		case (job.kind)
			JOB_CHAR: ch = job.ch;
			JOB_ERROR: ch = CHAR_NUL;
			JOB_ESCAPE: begin
				case (dig_q)
					2'd0: ch = CHAR_PERCENT;
					2'd1: ch = hex_char(octet[7:4]);
					default: ch = hex_char(octet[3:0]);
				endcase
				last = (dig_q == 2'd2) && (oct_idx_q == job.oct_last);
			end
			default: ch = CHAR_NUL;
		endcase
	end

	assign job_pop = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_idx_q   <= '0;
			dig_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q   <= 1'b1;
				out_char_q    <= ch;
				run_last_q    <= last;
				string_done_q <= last && (job.str_end || (job.kind == JOB_ERROR));
				malformed_q   <= (job.kind == JOB_ERROR);
				if (last) begin
					oct_idx_q <= '0;
					dig_q     <= '0;
				end else if (dig_q == 2'd2) begin
					oct_idx_q <= oct_idx_q + 2'd1;
					dig_q     <= '0;
				end else begin
					dig_q <= dig_q + 2'd1;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty       = !out_valid_q;
	assign out_char    = out_char_q;
	assign run_last    = run_last_q;
	assign string_done = string_done_q;
	assign malformed   = malformed_q;

	`ASSERT_IMP(a_digit_range, clk, arst_n, 1'b1, dig_q != 2'd3)
	`ASSERT_IMP(a_error_shape, clk, arst_n, out_valid_q && malformed_q,
		run_last_q && string_done_q && (out_char_q == CHAR_NUL))
	`ASSERT_IMP(a_pop_needs_job, clk, arst_n, job_pop, job_valid)

endmodule
